FILE: hw/rtl/gtg_pkg.sv
// Shared types, constants and the arctangent table of the go-to-goal drive controller.
package gtg_pkg;

  localparam int TAB_LEN = 24;

  localparam logic [2:0] CFG_YAW_GAIN    = 3'd0;
  localparam logic [2:0] CFG_LIN_GAIN    = 3'd1;
  localparam logic [2:0] CFG_MAX_YAW     = 3'd2;
  localparam logic [2:0] CFG_MAX_SPEED   = 3'd3;
  localparam logic [2:0] CFG_GOAL_TOL    = 3'd4;
  localparam logic [2:0] CFG_DEAD_OFFSET = 3'd5;
  localparam logic [2:0] CFG_POSE_TMO    = 3'd6;

  localparam logic [2:0] ST_WAIT_INPUT = 3'd0;
  localparam logic [2:0] ST_WAIT_GOAL  = 3'd1;
  localparam logic [2:0] ST_TIMEOUT    = 3'd2;
  localparam logic [2:0] ST_SAFE_STOP  = 3'd3;
  localparam logic [2:0] ST_REACHED    = 3'd4;
  localparam logic [2:0] ST_TRACKING   = 3'd5;
  localparam logic [2:0] ST_ROTATE     = 3'd6;

  localparam logic [16:0] ENTER_TH      = 17'd6371;
  localparam logic [16:0] EXIT_TH       = 17'd3641;
  localparam logic [16:0] TOL_FINAL_MIN = 17'd123;
  localparam logic [16:0] TOL_WAY_MIN   = 17'd184;
  localparam logic [16:0] HS_MIN        = 17'd3277;
  localparam logic [16:0] SLOW_MAX      = 17'd45875;
  localparam logic [16:0] ONE_Q16       = 17'd65536;
  localparam logic signed [25:0] PI_Q16 = 26'sd205887;
  localparam logic signed [43:0] CORDIC_K_Q30 = 44'sd652032874;

  typedef struct packed {
    logic start;
    logic vect;
  } cd_cmd_t;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } ds_cmd_t;

  function automatic logic [31:0] gtg_atan(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/go_to_goal_drive_controller.sv
// Go-to-goal drive controller top level: sequencer, shared multiplier and state.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------------
//   config   | cfg_we_i                   | cfg_addr_i, cfg_wdata_i
//   input    | in_valid_i / in_ready_o    | pose, target, goal tag, flags, pose age
//   output   | out_valid_o / out_ready_i  | speed, yaw rate, state, errors, reached
//
// One transaction at a time: a stop case (no pose, no goal, timeout, safety stop) is
// decided in the decode state; reached, rotate and tracking wait on the 25-step square root,
// and tracking also on the 16-step cosine CORDIC and the 17-step slowdown divide.
// Reset clears the controller state and loads the register defaults; no clearing pass.
// A stalled output holds the result; no new input is taken until it is delivered.
module go_to_goal_drive_controller import gtg_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic        [2:0]  cfg_addr_i,
  input  logic        [15:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [23:0] pose_x_i,
  input  logic signed [23:0] pose_y_i,
  input  logic signed [15:0] pose_heading_i,
  input  logic signed [23:0] target_x_i,
  input  logic signed [23:0] target_y_i,
  input  logic        [31:0] goal_tag_i,
  input  logic               target_is_final_i,
  input  logic               pose_valid_i,
  input  logic               goal_valid_i,
  input  logic        [15:0] pose_age_ms_i,
  input  logic               safety_stop_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [15:0] speed_cmd_o,
  output logic signed [15:0] yaw_rate_cmd_o,
  output logic        [2:0]  state_code_o,
  output logic        [23:0] distance_error_o,
  output logic signed [15:0] heading_error_o,
  output logic               reached_flag_o
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DEC  = 5'd1;
  localparam logic [4:0] S_M1   = 5'd2;
  localparam logic [4:0] S_M2   = 5'd3;
  localparam logic [4:0] S_M3   = 5'd4;
  localparam logic [4:0] S_W1   = 5'd5;
  localparam logic [4:0] S_DEC2 = 5'd6;
  localparam logic [4:0] S_Y1   = 5'd7;
  localparam logic [4:0] S_Y2   = 5'd8;
  localparam logic [4:0] S_Y3   = 5'd9;
  localparam logic [4:0] S_T1   = 5'd10;
  localparam logic [4:0] S_T2   = 5'd11;
  localparam logic [4:0] S_T3   = 5'd12;
  localparam logic [4:0] S_T4   = 5'd13;
  localparam logic [4:0] S_T5   = 5'd14;
  localparam logic [4:0] S_T6   = 5'd15;
  localparam logic [4:0] S_T7   = 5'd16;
  localparam logic [4:0] S_T8   = 5'd17;
  localparam logic [4:0] S_OUT  = 5'd18;

  // (2^18 + 1) / 5: floor(x * RECIP5 / 2^18) == floor(x / 5) for x < 2^18
  localparam logic signed [25:0] RECIP5 = 26'sd52429;

  function automatic logic signed [15:0] clamp_rate(input logic signed [23:0] r,
                                                    input logic [14:0] lim);
    logic signed [23:0] l, nl;
    l  = $signed({9'd0, lim});
    nl = -l;
    if (r > l) return l[15:0];
    else if (r < nl) return nl[15:0];
    else return r[15:0];
  endfunction

  logic [4:0] state_q, state_d;

  logic [15:0] yaw_gain_q, lin_gain_q, max_speed_q, goal_tol_q, pose_tmo_q;
  logic [14:0] max_yaw_q, dead_off_q;

  logic               reached_q, reached_d, rot_q, rot_d;
  logic        [31:0] last_tag_q, last_tag_d;

  logic signed [24:0] dx_q, dy_q;
  logic signed [15:0] hd_q;
  logic        [31:0] tag_q;
  logic               fin_q, pv_q, gv_q, ss_q;
  logic        [15:0] age_q;

  logic [49:0] acc_q, acc_d, sq_q, sq_d;
  logic [33:0] tolsq_q, tolsq_d;
  logic [16:0] a_q, a_d, h_q, h_d, s_q, s_d;
  logic signed [23:0] yraw_q, yraw_d;
  logic [40:0] num_q, num_d;
  logic        cos_en_q, cos_en_d, zv;

  logic [15:0] speed_q, speed_d;
  logic signed [15:0] yaw_q, yaw_d, head_q, head_d;
  logic [2:0]  st_q, st_d;
  logic [23:0] dist_q, dist_d;
  logic        rflag_q, rflag_d;

  logic signed [41:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [67:0] prod_q, ysum;

  cd_cmd_t     cd_cmd;
  ds_cmd_t     ds_cmd;
  logic [49:0] ds_opa;
  logic [24:0] ds_den, ds_res;
  logic        ds_busy, cd_busy;
  logic signed [43:0] cd_x, cd_xr;
  logic [32:0] cd_z;
  logic [16:0] cd_ang;

  logic [16:0] tol, tri_m, errx, off17, ratio;
  logic [17:0] tri_tol;
  logic signed [16:0] e_val;
  logic [31:0] zt;
  logic [15:0] err_n, yabs;
  logic [29:0] cval;
  logic [16:0] cclip;
  logic [39:0] vfin;
  logic [24:0] den_c;
  logic        accept, rot_n;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign zv         = (dx_q == 25'sd0) && (dy_q == 25'sd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_gain_q  <= 16'd512;
      lin_gain_q  <= 16'd256;
      max_yaw_q   <= 15'd6144;
      max_speed_q <= 16'd512;
      goal_tol_q  <= 16'd102;
      dead_off_q  <= 15'd0;
      pose_tmo_q  <= 16'd800;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_YAW_GAIN:    yaw_gain_q  <= cfg_wdata_i;
        CFG_LIN_GAIN:    lin_gain_q  <= cfg_wdata_i;
        CFG_MAX_YAW:     max_yaw_q   <= cfg_wdata_i[14:0];
        CFG_MAX_SPEED:   max_speed_q <= cfg_wdata_i;
        CFG_GOAL_TOL:    goal_tol_q  <= cfg_wdata_i;
        CFG_DEAD_OFFSET: dead_off_q  <= cfg_wdata_i[14:0];
        CFG_POSE_TMO:    pose_tmo_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_q  <= $signed({target_x_i[23], target_x_i}) - $signed({pose_x_i[23], pose_x_i});
      dy_q  <= $signed({target_y_i[23], target_y_i}) - $signed({pose_y_i[23], pose_y_i});
      hd_q  <= pose_heading_i;
      tag_q <= goal_tag_i;
      fin_q <= target_is_final_i;
      pv_q  <= pose_valid_i;
      gv_q  <= goal_valid_i;
      age_q <= pose_age_ms_i;
      ss_q  <= safety_stop_i;
    end
  end

  always_comb begin
    tri_tol = {2'd0, goal_tol_q} + {1'b0, goal_tol_q, 1'b0};
    if (fin_q) tol = ({1'b0, goal_tol_q} > TOL_FINAL_MIN) ? {1'b0, goal_tol_q} : TOL_FINAL_MIN;
    else tol = (tri_tol[17:1] < TOL_WAY_MIN) ? TOL_WAY_MIN : tri_tol[17:1];
    tri_m = {2'd0, max_yaw_q} + {1'b0, max_yaw_q, 1'b0};
    zt    = zv ? 32'd0 : (cd_z[31:0] + 32'h8000);
    err_n = zt[31:16] - hd_q;
    errx  = {err_n[15], err_n};
    off17 = {2'd0, dead_off_q};
    rot_n = (a_q > ENTER_TH) ? 1'b1 : rot_q;
    if (a_q < EXIT_TH) rot_n = 1'b0;
    if (!rot_n) e_val = $signed({head_q[15], head_q});
    else if (a_q > off17) begin
      if (head_q > 16'sd0) e_val = $signed({head_q[15], head_q}) - $signed(off17);
      else e_val = $signed({head_q[15], head_q}) + $signed(off17);
    end else e_val = 17'sd0;
    ysum  = prod_q + 68'sd67108864;
    yabs  = yaw_q[15] ? (16'd0 - yaw_q) : yaw_q;
    den_c = (prod_q[24:0] < 25'd4096) ? 25'd4096 : prod_q[24:0];
    cd_xr = cd_x + 44'sd8192;
    cval  = cd_xr[43:14];
    if (!cos_en_q || cval[29]) cclip = 17'd0;
    else if (cval > 30'd65536) cclip = ONE_Q16;
    else cclip = cval[16:0];
    ratio = (ds_res[16:0] > SLOW_MAX) ? SLOW_MAX : ds_res[16:0];
    vfin  = prod_q[63:24];
  end

  always_comb begin
    state_d    = state_q;
    reached_d  = reached_q;
    rot_d      = rot_q;
    last_tag_d = last_tag_q;
    acc_d      = acc_q;
    sq_d       = sq_q;
    tolsq_d    = tolsq_q;
    a_d        = a_q;
    h_d        = h_q;
    s_d        = s_q;
    yraw_d     = yraw_q;
    num_d      = num_q;
    cos_en_d   = cos_en_q;
    speed_d    = speed_q;
    yaw_d      = yaw_q;
    head_d     = head_q;
    st_d       = st_q;
    dist_d     = dist_q;
    rflag_d    = rflag_q;
    mul_a      = '0;
    mul_b      = '0;
    cd_cmd     = '0;
    cd_ang     = a_q;
    ds_cmd     = '0;
    ds_opa     = '0;
    ds_den     = den_c;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_DEC;
      end
      S_DEC: begin
        speed_d = '0;
        yaw_d   = '0;
        dist_d  = '0;
        head_d  = '0;
        rflag_d = 1'b0;
        if (!pv_q) begin
          st_d = ST_WAIT_INPUT;
          state_d = S_OUT;
        end else if (!gv_q) begin
          st_d = ST_WAIT_GOAL;
          state_d = S_OUT;
        end else if (age_q > pose_tmo_q) begin
          st_d = ST_TIMEOUT;
          state_d = S_OUT;
        end else if (ss_q) begin
          st_d = ST_SAFE_STOP;
          state_d = S_OUT;
        end else begin
          if (tag_q != last_tag_q) begin
            last_tag_d = tag_q;
            reached_d  = 1'b0;
            rot_d      = 1'b0;
          end
          mul_a  = 42'(dx_q);
          mul_b  = 26'(dx_q);
          cd_cmd = '{start: 1'b1, vect: 1'b1};
          state_d = S_M1;
        end
      end
      S_M1: begin
        acc_d = prod_q[49:0];
        mul_a = 42'(dy_q);
        mul_b = 26'(dy_q);
        state_d = S_M2;
      end
      S_M2: begin
        sq_d  = acc_q + prod_q[49:0];
        mul_a = $signed({25'd0, tol});
        mul_b = $signed({9'd0, tol});
        state_d = S_M3;
      end
      S_M3: begin
        tolsq_d = prod_q[33:0];
        ds_cmd  = '{start: 1'b1, is_sqrt: 1'b1};
        ds_opa  = sq_q;
        state_d = S_W1;
      end
      S_W1: begin
        if (!ds_busy && !cd_busy) begin
          dist_d = ds_res[24] ? 24'hFFFFFF : ds_res[23:0];
          head_d = $signed(err_n);
          a_d    = err_n[15] ? (17'd0 - errx) : errx;
          state_d = S_DEC2;
        end
      end
      S_DEC2: begin
        if (reached_q) begin
          st_d    = ST_REACHED;
          rflag_d = 1'b1;
          state_d = S_OUT;
        end else if (sq_q <= {16'd0, tolsq_q}) begin
          reached_d = 1'b1;
          rot_d     = 1'b0;
          st_d      = ST_REACHED;
          rflag_d   = 1'b1;
          state_d   = S_OUT;
        end else begin
          rot_d = rot_n;
          mul_a = $signed({26'd0, yaw_gain_q});
          mul_b = 26'(e_val);
          cos_en_d = (a_q < 17'd16384);
          if (!rot_n) begin
            cd_cmd = '{start: (a_q < 17'd16384), vect: 1'b0};
          end
          state_d = S_Y1;
        end
      end
      S_Y1: begin
        mul_a = $signed(prod_q[41:0]);
        mul_b = PI_Q16;
        state_d = S_Y2;
      end
      S_Y2: begin
        yraw_d  = ysum[50:27];
        mul_a   = $signed({25'd0, tri_m});
        mul_b   = RECIP5;
        state_d = S_Y3;
      end
      S_Y3: begin
        if (rot_q) begin
          yaw_d   = clamp_rate(yraw_q, max_yaw_q);
          st_d    = ST_ROTATE;
          state_d = S_OUT;
        end else begin
          yaw_d   = clamp_rate(yraw_q, prod_q[32:18]);
          state_d = S_T1;
        end
      end
      S_T1: begin
        mul_a = $signed({26'd0, yabs});
        mul_b = 26'sd1000;
        state_d = S_T2;
      end
      S_T2: begin
        num_d = {prod_q[24:0], 16'd0};
        mul_a = $signed({27'd0, max_yaw_q});
        mul_b = 26'sd1000;
        state_d = S_T3;
      end
      S_T3: begin
        ds_cmd = '{start: 1'b1, is_sqrt: 1'b0};
        ds_opa = {9'd0, num_q};
        ds_den = den_c;
        state_d = S_T4;
      end
      S_T4: begin
        if (!ds_busy && !cd_busy) begin
          h_d = (cclip < HS_MIN) ? HS_MIN : cclip;
          s_d = ONE_Q16 - ratio;
          state_d = S_T5;
        end
      end
      S_T5: begin
        mul_a = $signed({18'd0, dist_q});
        mul_b = $signed({10'd0, lin_gain_q});
        state_d = S_T6;
      end
      S_T6: begin
        mul_a = $signed(prod_q[41:0]);
        mul_b = $signed({9'd0, h_q});
        state_d = S_T7;
      end
      S_T7: begin
        mul_a = $signed(prod_q[57:16]);
        mul_b = $signed({9'd0, s_q});
        state_d = S_T8;
      end
      S_T8: begin
        speed_d = (vfin > {24'd0, max_speed_q}) ? max_speed_q : vfin[15:0];
        st_d    = ST_TRACKING;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      reached_q  <= 1'b0;
      rot_q      <= 1'b0;
      last_tag_q <= '0;
      cos_en_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      reached_q  <= reached_d;
      rot_q      <= rot_d;
      last_tag_q <= last_tag_d;
      cos_en_q   <= cos_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= mul_a * mul_b;
    acc_q   <= acc_d;
    sq_q    <= sq_d;
    tolsq_q <= tolsq_d;
    a_q     <= a_d;
    h_q     <= h_d;
    s_q     <= s_d;
    yraw_q  <= yraw_d;
    num_q   <= num_d;
    speed_q <= speed_d;
    yaw_q   <= yaw_d;
    head_q  <= head_d;
    st_q    <= st_d;
    dist_q  <= dist_d;
    rflag_q <= rflag_d;
  end

  gtg_cordic #(
    .Iterations(CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cd_cmd),
    .dx_i  (dx_q),
    .dy_i  (dy_q),
    .ang_i (cd_ang),
    .busy_o(cd_busy),
    .x_o   (cd_x),
    .z_o   (cd_z)
  );

  gtg_divsqrt u_divsqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (ds_cmd),
    .opa_i (ds_opa),
    .den_i (ds_den),
    .busy_o(ds_busy),
    .res_o (ds_res)
  );

  assign out_valid_o      = (state_q == S_OUT);
  assign speed_cmd_o      = speed_q;
  assign yaw_rate_cmd_o   = yaw_q;
  assign state_code_o     = st_q;
  assign distance_error_o = dist_q;
  assign heading_error_o  = head_q;
  assign reached_flag_o   = rflag_q;

endmodule

FILE: hw/rtl/gtg_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
module gtg_cordic import gtg_pkg::*; #(
  parameter int Iterations = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cd_cmd_t            cmd_i,
  input  logic signed [24:0] dx_i,
  input  logic signed [24:0] dy_i,
  input  logic        [16:0] ang_i,
  output logic               busy_o,
  output logic signed [43:0] x_o,
  output logic        [32:0] z_o
);

  localparam int N  = (Iterations > TAB_LEN) ? TAB_LEN : Iterations;
  localparam int CW = $clog2(N);

  logic          busy_q, busy_d, vect_q, vect_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic signed [43:0] x_q, x_d, y_q, y_d, xs, ys, x0, y0;
  logic [32:0] z_q, z_d, at;
  logic        neg;

  always_comb begin
    xs  = x_q >>> cnt_q;
    ys  = y_q >>> cnt_q;
    neg = vect_q ? y_q[43] : ~z_q[32];
    at  = {1'b0, gtg_atan(5'(cnt_q))};
    x0  = {{3{dx_i[24]}}, dx_i, 16'd0};
    y0  = {{3{dy_i[24]}}, dy_i, 16'd0};
    busy_d = busy_q;
    vect_d = vect_q;
    cnt_d  = cnt_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      vect_d = cmd_i.vect;
      cnt_d  = '0;
      if (cmd_i.vect) begin
        if (!dx_i[24]) begin
          x_d = x0;
          y_d = y0;
          z_d = 33'd0;
        end else if (!dy_i[24]) begin
          x_d = y0;
          y_d = -x0;
          z_d = 33'h040000000;
        end else begin
          x_d = -y0;
          y_d = x0;
          z_d = 33'h0C0000000;
        end
      end else begin
        x_d = CORDIC_K_Q30;
        y_d = '0;
        z_d = {ang_i, 16'd0};
      end
    end else if (busy_q) begin
      if (neg) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(N - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      vect_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      vect_q <= vect_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign busy_o = busy_q;
  assign x_o    = x_q;
  assign z_o    = z_q;

endmodule

FILE: hw/rtl/gtg_divsqrt.sv
// Shared radix-2 restoring divider and square root on one subtractor.
module gtg_divsqrt import gtg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ds_cmd_t     cmd_i,
  input  logic [49:0] opa_i,
  input  logic [24:0] den_i,
  output logic        busy_o,
  output logic [24:0] res_o
);

  localparam logic [4:0] DIV_LAST  = 5'd16;
  localparam logic [4:0] SQRT_LAST = 5'd24;

  logic        busy_q, busy_d, sqrt_q, sqrt_d, ge;
  logic [4:0]  cnt_q, cnt_d;
  logic [41:0] rem_q, rem_d, dsh_q, dsh_d, opa, opb;
  logic [42:0] diff;
  logic [49:0] rad_q, rad_d;
  logic [24:0] qr_q, qr_d;

  always_comb begin
    opa  = sqrt_q ? {rem_q[39:0], rad_q[49:48]} : rem_q;
    opb  = sqrt_q ? {15'd0, qr_q, 2'b01} : dsh_q;
    diff = {1'b0, opa} - {1'b0, opb};
    ge   = ~diff[42];
    busy_d = busy_q;
    sqrt_d = sqrt_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    rad_d  = rad_q;
    qr_d   = qr_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      sqrt_d = cmd_i.is_sqrt;
      cnt_d  = cmd_i.is_sqrt ? SQRT_LAST : DIV_LAST;
      rem_d  = cmd_i.is_sqrt ? 42'd0 : opa_i[41:0];
      dsh_d  = {1'b0, den_i, 16'd0};
      rad_d  = opa_i;
      qr_d   = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[41:0] : opa;
      qr_d  = {qr_q[23:0], ge};
      dsh_d = dsh_q >> 1;
      rad_d = rad_q << 2;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 5'd0) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sqrt_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      sqrt_q <= sqrt_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    rad_q <= rad_d;
    qr_q  <= qr_d;
  end

  assign busy_o = busy_q;
  assign res_o  = qr_q;

endmodule

FILE: hw/rtl/gtg_checker.sv
// Port-level assertions for the go-to-goal drive controller and their bind.
module gtg_checker import gtg_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic        [2:0]  cfg_addr_i,
  input logic        [15:0] cfg_wdata_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic signed [23:0] pose_x_i,
  input logic signed [23:0] pose_y_i,
  input logic signed [15:0] pose_heading_i,
  input logic signed [23:0] target_x_i,
  input logic signed [23:0] target_y_i,
  input logic        [31:0] goal_tag_i,
  input logic               target_is_final_i,
  input logic               pose_valid_i,
  input logic               goal_valid_i,
  input logic        [15:0] pose_age_ms_i,
  input logic               safety_stop_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic        [15:0] speed_cmd_o,
  input logic signed [15:0] yaw_rate_cmd_o,
  input logic        [2:0]  state_code_o,
  input logic        [23:0] distance_error_o,
  input logic signed [15:0] heading_error_o,
  input logic               reached_flag_o
);

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after an input transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(speed_cmd_o) &&
      $stable(yaw_rate_cmd_o) && $stable(state_code_o) && $stable(distance_error_o)))
    else $error("stalled result changed");

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (state_code_o == ST_WAIT_INPUT || state_code_o == ST_WAIT_GOAL ||
      state_code_o == ST_TIMEOUT || state_code_o == ST_SAFE_STOP)) |->
    (speed_cmd_o == 16'd0 && yaw_rate_cmd_o == 16'sd0 && distance_error_o == 24'd0 &&
      heading_error_o == 16'sd0 && !reached_flag_o))
    else $error("stop result carries nonzero fields");

  a_reached_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reached_flag_o) |->
    (speed_cmd_o == 16'd0 && yaw_rate_cmd_o == 16'sd0 && state_code_o == ST_REACHED))
    else $error("reached result is moving");

endmodule

bind go_to_goal_drive_controller gtg_checker u_gtg_checker (.*);

FILE: tb/go_to_goal_drive_controller_test.sv
// Self-checking testbench of the go-to-goal drive controller: predictor, scoreboard, stimulus.
module go_to_goal_drive_controller_test;
  import gtg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 100;
  localparam int CORDIC_STEPS = 16;

  typedef struct {
    logic signed [23:0] pose_x;
    logic signed [23:0] pose_y;
    logic signed [15:0] heading;
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic [31:0] tag;
    logic goal_last;
    logic pose_ok;
    logic goal_ok;
    logic [15:0] age;
    logic stop;
  } tick_t;

  typedef struct {
    logic [15:0] speed;
    logic signed [15:0] yaw_rate;
    logic [2:0] state;
    logic [23:0] range_err;
    logic signed [15:0] herr;
    logic reached;
  } cmd_t;

  class cmd_scoreboard;
    cmd_t expected_cmds[$];
    int errors;
    int checked;
    int state_hits[8];
    bit [31:0] atan_lut[24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};
    longint unsigned yaw_gain, lin_gain, max_yaw, max_speed, goal_tol, dead_off, tmo;
    bit reached_q, rotating_q;
    bit [31:0] last_tag;

    function new();
      yaw_gain = 512; lin_gain = 256; max_yaw = 6144; max_speed = 512;
      goal_tol = 102; dead_off = 0; tmo = 800;
      reached_q = 0; rotating_q = 0; last_tag = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        CFG_YAW_GAIN: yaw_gain = val;
        CFG_LIN_GAIN: lin_gain = val;
        CFG_MAX_YAW: max_yaw = val[14:0];
        CFG_MAX_SPEED: max_speed = val;
        CFG_GOAL_TOL: goal_tol = val;
        CFG_DEAD_OFFSET: dead_off = val[14:0];
        CFG_POSE_TMO: tmo = val;
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function bit [31:0] bearing(longint dx, longint dy);
      longint x, y, t, xs, ys;
      bit [31:0] z;
      x = dx * 65536;
      y = dy * 65536;
      z = 0;
      if (dx == 0 && dy == 0) return 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = 32'h4000_0000;
        end else begin
          t = x; x = -y; y = t; z = 32'hC000_0000;
        end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y < 0) begin
          x = x - ys; y = y + xs; z = z - atan_lut[i];
        end else begin
          x = x + ys; y = y - xs; z = z + atan_lut[i];
        end
      end
      return z;
    endfunction

    function longint cosine(longint a);
      longint x, y, z, xs, ys, c;
      if (a >= 16384) return 0;
      x = 652032874;
      y = 0;
      z = a * 65536;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - atan_lut[i];
        end else begin
          x = x + ys; y = y - xs; z = z + atan_lut[i];
        end
      end
      c = (x + 8192) >>> 14;
      if (c < 0) c = 0;
      if (c > 65536) c = 65536;
      return c;
    endfunction

    function longint yaw_rate(longint e, longint lim);
      longint r;
      r = (longint'(yaw_gain) * e * 205887 + (longint'(1) << 26)) >>> 27;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
    endfunction

    function void predict_command(tick_t t);
      cmd_t c;
      longint dx, dy, err, a, yaw, e, h, den, ratio, s;
      longint unsigned sq, dist_v, tol, v;
      bit [31:0] ang;
      logic [15:0] tgt;
      c = '{default: '0};
      if (!t.pose_ok) c.state = ST_WAIT_INPUT;
      else if (!t.goal_ok) c.state = ST_WAIT_GOAL;
      else if (t.age > tmo) c.state = ST_TIMEOUT;
      else if (t.stop) c.state = ST_SAFE_STOP;
      else begin
        dx = longint'(t.target_x) - longint'(t.pose_x);
        dy = longint'(t.target_y) - longint'(t.pose_y);
        sq = dx * dx + dy * dy;
        dist_v = int_sqrt(sq);
        if (dist_v > 24'hFF_FFFF) dist_v = 24'hFF_FFFF;
        ang = bearing(dx, dy) + 32'h8000;
        tgt = ang[31:16];
        c.herr = tgt - t.heading;
        err = c.herr;
        a = err < 0 ? -err : err;
        c.range_err = 24'(dist_v);
        yaw = 0;
        if (t.tag != last_tag) begin
          last_tag = t.tag; reached_q = 0; rotating_q = 0;
        end
        if (t.goal_last) tol = goal_tol > 123 ? goal_tol : 123;
        else begin
          tol = (goal_tol * 3) >> 1;
          if (tol < 184) tol = 184;
        end
        if (reached_q) begin
          c.state = ST_REACHED; c.reached = 1;
        end else if (sq <= tol * tol) begin
          reached_q = 1; rotating_q = 0; c.state = ST_REACHED; c.reached = 1;
        end else begin
          if (a > 6371) rotating_q = 1;
          if (a < 3641) rotating_q = 0;
          if (rotating_q) begin
            c.state = ST_ROTATE;
            if (a > longint'(dead_off)) e = err > 0 ? err - dead_off : err + dead_off;
            else e = 0;
            yaw = yaw_rate(e, max_yaw);
          end else begin
            c.state = ST_TRACKING;
            yaw = yaw_rate(err, (longint'(max_yaw) * 3) / 5);
            h = cosine(a);
            if (h < 3277) h = 3277;
            den = longint'(max_yaw) * 1000;
            if (den < 4096) den = 4096;
            ratio = ((yaw < 0 ? -yaw : yaw) * 1000 * 65536) / den;
            if (ratio > 45875) ratio = 45875;
            s = 65536 - ratio;
            v = lin_gain * dist_v;
            v = (v * h) >> 16;
            v = (v * s) >> 16;
            v = v >> 8;
            c.speed = 16'(v > max_speed ? max_speed : v);
          end
        end
        c.yaw_rate = 16'(yaw);
      end
      expected_cmds.push_back(c);
    endfunction

    function void check_command(cmd_t act);
      cmd_t exp_c;
      if (expected_cmds.size() == 0) begin
        $display("%t unexpected command: state %0d", $realtime, act.state);
        errors++;
        return;
      end
      exp_c = expected_cmds.pop_front();
      checked++;
      state_hits[exp_c.state]++;
      if (act.speed !== exp_c.speed) begin
        $display("%t speed exp %0d act %0d", $realtime, exp_c.speed, act.speed);
        errors++;
      end
      if (act.yaw_rate !== exp_c.yaw_rate) begin
        $display("%t yaw rate exp %0d act %0d", $realtime, exp_c.yaw_rate, act.yaw_rate);
        errors++;
      end
      if (act.state !== exp_c.state) begin
        $display("%t state exp %0d act %0d", $realtime, exp_c.state, act.state);
        errors++;
      end
      if (act.range_err !== exp_c.range_err) begin
        $display("%t distance exp %0d act %0d", $realtime, exp_c.range_err, act.range_err);
        errors++;
      end
      if (act.herr !== exp_c.herr) begin
        $display("%t heading err exp %0d act %0d", $realtime, exp_c.herr, act.herr);
        errors++;
      end
      if (act.reached !== exp_c.reached) begin
        $display("%t reached exp %0d act %0d", $realtime, exp_c.reached, act.reached);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [2:0] cfg_addr_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic signed [23:0] pose_x_i = '0, pose_y_i = '0, target_x_i = '0, target_y_i = '0;
  logic signed [15:0] pose_heading_i = '0;
  logic [31:0] goal_tag_i = '0;
  logic target_is_final_i = 0, pose_valid_i = 0, goal_valid_i = 0, safety_stop_i = 0;
  logic [15:0] pose_age_ms_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic [15:0] speed_cmd_o;
  logic signed [15:0] yaw_rate_cmd_o;
  logic [2:0] state_code_o;
  logic [23:0] distance_error_o;
  logic signed [15:0] heading_error_o;
  logic reached_flag_o;

  go_to_goal_drive_controller u_top (.*);

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  cmd_scoreboard sb = new();
  bit idle_on = 1;
  bit long_hold_req = 0;
  int settings_used = 1;
  int quiet_cycles = 0;
  logic [31:0] cur_tag;
  logic signed [23:0] cur_tx, cur_ty;
  logic cur_final;

  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 0;
        out_ready_i <= 0;
        repeat (400) @(posedge clk_i);
      end
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      out_ready_i <= 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_command('{speed_cmd_o, yaw_rate_cmd_o, state_code_o, distance_error_o,
                         heading_error_o, reached_flag_o});
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_tick(tick_t t);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    pose_x_i <= t.pose_x;
    pose_y_i <= t.pose_y;
    pose_heading_i <= t.heading;
    target_x_i <= t.target_x;
    target_y_i <= t.target_y;
    goal_tag_i <= t.tag;
    target_is_final_i <= t.goal_last;
    pose_valid_i <= t.pose_ok;
    goal_valid_i <= t.goal_ok;
    pose_age_ms_i <= t.age;
    safety_stop_i <= t.stop;
    do @(posedge clk_i); while (!in_ready_o);
    sb.predict_command(t);
  endtask

  task automatic drain();
    @(posedge clk_i);
    in_valid_i <= 0;
    while (sb.expected_cmds.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic load_regs(logic [15:0] yg, logic [15:0] lg, logic [15:0] my,
                           logic [15:0] ms, logic [15:0] gt, logic [15:0] dof,
                           logic [15:0] tm);
    write_reg(CFG_YAW_GAIN, yg);
    write_reg(CFG_LIN_GAIN, lg);
    write_reg(CFG_MAX_YAW, my);
    write_reg(CFG_MAX_SPEED, ms);
    write_reg(CFG_GOAL_TOL, gt);
    write_reg(CFG_DEAD_OFFSET, dof);
    write_reg(CFG_POSE_TMO, tm);
    settings_used++;
  endtask

  function automatic logic signed [23:0] rand_coord();
    if ($urandom_range(0, 7) == 0) return 24'($urandom);
    return 24'(int'($urandom_range(0, 40000)) - 20000);
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int mode;
    if ($urandom_range(0, 99) < 6) begin
      cur_tag = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
      cur_tx = rand_coord();
      cur_ty = rand_coord();
      cur_final = 1'($urandom_range(0, 1));
    end
    t.target_x = cur_tx;
    t.target_y = cur_ty;
    t.tag = cur_tag;
    t.goal_last = cur_final;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      t.pose_x = 24'(cur_tx + int'($urandom_range(0, 600)) - 300);
      t.pose_y = 24'(cur_ty + int'($urandom_range(0, 600)) - 300);
    end else if (mode == 2) begin
      t.pose_x = 24'($urandom);
      t.pose_y = 24'($urandom);
    end else begin
      t.pose_x = 24'(cur_tx + int'($urandom_range(0, 40000)) - 20000);
      t.pose_y = 24'(cur_ty + int'($urandom_range(0, 40000)) - 20000);
    end
    t.heading = 16'($urandom);
    t.pose_ok = $urandom_range(0, 19) != 0;
    t.goal_ok = $urandom_range(0, 19) != 0;
    t.age = 16'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'(sb.tmo)));
    t.stop = $urandom_range(0, 19) == 0;
    return t;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_tick(random_tick());
  endtask

  function automatic tick_t mk(int px, int py, int hd, int tx, int ty, logic [31:0] tag,
                               logic fin, logic pv, logic gv, logic [15:0] age, logic stp);
    tick_t t;
    t = '{px, py, hd, tx, ty, tag, fin, pv, gv, age, stp};
    return t;
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // stop cases, in priority order
    send_tick(mk(0, 0, 0, 5000, 0, 1, 0, 0, 1, 0, 1));
    send_tick(mk(0, 0, 0, 5000, 0, 1, 0, 1, 0, 0, 1));
    send_tick(mk(0, 0, 0, 5000, 0, 1, 0, 1, 1, 801, 1));
    send_tick(mk(0, 0, 0, 5000, 0, 1, 0, 1, 1, 65535, 0));
    send_tick(mk(0, 0, 0, 5000, 0, 1, 0, 1, 1, 800, 1));
    // tag 0 first goal, tracking then rotate with hysteresis
    send_tick(mk(0, 0, 0, 5000, 0, 0, 0, 1, 1, 800, 0));
    send_tick(mk(0, 0, 16000, 5000, 0, 0, 0, 1, 1, 0, 0));
    send_tick(mk(0, 0, 5000, 5000, 0, 0, 0, 1, 1, 0, 0));
    send_tick(mk(0, 0, -3000, 5000, 0, 0, 0, 1, 1, 0, 0));
    send_tick(mk(0, 0, -32768, 5000, 0, 0, 1, 1, 1, 0, 0));
    send_tick(mk(0, 0, 32767, 5000, 0, 0, 1, 1, 1, 0, 0));
    // zero vector, reached latch, then a new tag
    send_tick(mk(100, -100, 0, 100, -100, 7, 1, 1, 1, 0, 0));
    send_tick(mk(0, 0, 0, 9000, 9000, 7, 1, 1, 1, 0, 0));
    send_tick(mk(0, 0, 0, 9000, 9000, 32'hFFFF_FFFF, 1, 1, 1, 0, 0));
    send_tick(mk(0, 0, 0, 123, 0, 8, 1, 1, 1, 0, 0));
    send_tick(mk(0, 0, 0, 124, 0, 9, 1, 1, 1, 0, 0));
    send_tick(mk(0, 0, 0, 184, 0, 10, 0, 1, 1, 0, 0));
    send_tick(mk(0, 0, 0, 185, 0, 11, 0, 1, 1, 0, 0));
    // full-scale corners, distance saturation
    send_tick(mk(-8388608, -8388608, 0, 8388607, 8388607, 12, 0, 1, 1, 0, 0));
    send_tick(mk(8388607, 8388607, -32768, -8388608, -8388608, 13, 0, 1, 1, 0, 0));
    send_tick(mk(8388607, -8388608, 12345, -8388608, 8388607, 14, 1, 1, 1, 0, 0));
    drain();

    cur_tag = 1; cur_tx = 3000; cur_ty = -2000; cur_final = 0;
    random_phase(80);
    drain();

    load_regs(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF);
    long_hold_req = 1;
    random_phase(40);
    send_tick(mk(0, 0, 0, 100000, 0, 77, 1, 1, 1, 0, 0));
    random_phase(40);
    drain();

    load_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    random_phase(60);
    drain();

    load_regs(16'd300, 16'd1, 16'd1, 16'd20, 16'd200, 16'd4000, 16'd1000);
    random_phase(60);
    drain();

    load_regs($urandom_range(256, 2048), $urandom_range(128, 1024),
              $urandom_range(1000, 12000), $urandom_range(200, 4000),
              $urandom_range(50, 400), $urandom_range(0, 2000), $urandom_range(200, 2000));
    random_phase(60);
    drain();

    idle_on = 0;
    load_regs(16'd512, 16'd256, 16'd6144, 16'd512, 16'd102, 16'd0, 16'd800);
    random_phase(80);
    drain();

    $display("Checked %0d commands under %0d register settings", sb.checked, settings_used);
    $display("States: wait %0d/%0d timeout %0d stop %0d reached %0d track %0d rotate %0d",
             sb.state_hits[ST_WAIT_INPUT], sb.state_hits[ST_WAIT_GOAL],
             sb.state_hits[ST_TIMEOUT], sb.state_hits[ST_SAFE_STOP],
             sb.state_hits[ST_REACHED], sb.state_hits[ST_TRACKING], sb.state_hits[ST_ROTATE]);
    if (sb.errors == 0 && sb.expected_cmds.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
